[design/rcpwm_pkg.sv]
// Package for the RC pulse receiver mode control core.
// Holds mode, servo, request, notification, switch and sequencer codes, register indexes,
// register reset values and helpers. No dependencies.
package rcpwm_pkg;

   // receiver mode codes
   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_READY    = 3'd1,
      MODE_FAULT    = 3'd2,
      MODE_ACTIVE   = 3'd3,
      MODE_PASS     = 3'd4,
      MODE_FAILSAFE = 3'd5
   } mode_type;

   // servo mode requests
   typedef enum logic [1:0] {
      SERVO_NONE     = 2'd0,
      SERVO_FAILSAFE = 2'd1,
      SERVO_PASS     = 2'd2,
      SERVO_AUTO     = 2'd3
   } servo_type;

   // request kinds
   typedef enum logic [1:0] {
      REQ_EDGE      = 2'd0,
      REQ_HEARTBEAT = 2'd1,
      REQ_STARTUP   = 2'd2,
      REQ_RESET     = 2'd3
   } req_kind_type;

   // notifications
   typedef enum logic [1:0] {
      NOTE_NONE   = 2'd0,
      NOTE_READY  = 2'd1,
      NOTE_ACTIVE = 2'd2,
      NOTE_FAULT  = 2'd3
   } note_type;

   // switch events
   typedef enum logic [1:0] {
      SW_NONE = 2'd0,
      SW_OFF  = 2'd1,
      SW_ON   = 2'd2
   } switch_type;

   // channel processing order: 2, 1, 3
   typedef enum logic [1:0] {
      STEP_CH2 = 2'd0,
      STEP_CH1 = 2'd1,
      STEP_CH3 = 2'd2
   } step_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_PICK   = 3'd1,
      ST_DIV    = 3'd2,
      ST_APPLY  = 3'd3,
      ST_FINISH = 3'd4
   } state_type;

   // register indexes
   localparam logic [2:0] CSR_SCALE         = 3'd0;
   localparam logic [2:0] CSR_QUALIFY_COUNT = 3'd1;
   localparam logic [2:0] CSR_PULSE_MIN     = 3'd2;
   localparam logic [2:0] CSR_PULSE_SHORT   = 3'd3;
   localparam logic [2:0] CSR_PULSE_LONG    = 3'd4;
   localparam logic [2:0] CSR_PULSE_MAX     = 3'd5;
   localparam logic [2:0] CSR_FRAME_TIMEOUT = 3'd6;

   // register reset values
   localparam logic [7:0]  SCALE_RESET         = 8'd80;
   localparam logic [7:0]  QUALIFY_COUNT_RESET = 8'd8;
   localparam logic [15:0] PULSE_MIN_RESET     = 16'd950;
   localparam logic [15:0] PULSE_SHORT_RESET   = 16'd1250;
   localparam logic [15:0] PULSE_LONG_RESET    = 16'd1750;
   localparam logic [15:0] PULSE_MAX_RESET     = 16'd2050;
   localparam logic [31:0] FRAME_TIMEOUT_RESET = 32'd2000000;

   // divider: one quotient bit per cycle
   localparam int DIV_STEPS = 32;
   localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

   // saturate a width to 16 bits
   function automatic logic [15:0] sat16(input logic [31:0] p);
      sat16 = (|p[31:16]) ? 16'hFFFF : p[15:0];
   endfunction

endpackage

[design/rcpwm_req_if.sv]
// Request channel interface of the RC pulse receiver core.
// Carries valid, ready and one pin-edge or control request. No dependencies.
interface rcpwm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [2:0]  edge_mask;
   logic [2:0]  pin_levels;
   logic [31:0] timestamp;

   modport source (output valid, req_type, edge_mask, pin_levels, timestamp, input ready);
   modport sink   (input valid, req_type, edge_mask, pin_levels, timestamp, output ready);
endinterface

[design/rcpwm_rsp_if.sv]
// Response channel interface of the RC pulse receiver core.
// Carries valid, ready and one result per request. No dependencies.
interface rcpwm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [1:0]  servo_cmd;
   logic        ch1_drive;
   logic        ch2_drive;
   logic [1:0]  drive_valid;
   logic [1:0]  switch_event;
   logic        heartbeat_ok;
   logic [1:0]  notify;
   logic [15:0] ch1_pulse;
   logic [15:0] ch2_pulse;
   logic [15:0] ch3_pulse;
   logic [2:0]  pulse_valid;

   modport source (output valid, mode, servo_cmd, ch1_drive, ch2_drive, drive_valid,
                   switch_event, heartbeat_ok, notify, ch1_pulse, ch2_pulse, ch3_pulse,
                   pulse_valid, input ready);
   modport sink   (input valid, mode, servo_cmd, ch1_drive, ch2_drive, drive_valid,
                   switch_event, heartbeat_ok, notify, ch1_pulse, ch2_pulse, ch3_pulse,
                   pulse_valid, output ready);
endinterface

[design/rcpwm_csr_if.sv]
// Register write channel interface of the RC pulse receiver core.
// Carries valid, ready, register index and write data. No dependencies.
interface rcpwm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/rc_pwm_receiver_mode_control_core.sv]
// Top level of the RC pulse receiver mode control core.
// Depends on rcpwm_pkg and the rcpwm_req_if, rcpwm_rsp_if and rcpwm_csr_if interfaces.

// Decodes three RC servo pulse inputs from timestamped pin edges and runs the receiver
// mode machine (none, ready, fault, active, passthrough, failsafe). Each request gives
// exactly one response. Requests are handled one at a time: channels of a pin-edge request
// are visited in the order 2, 1, 3, and every tick difference that must be turned into
// microseconds goes through one shared restoring divider that yields one quotient bit per
// cycle. A channel that needs a division passes through setup, 32 divide steps and an
// update; one without a division is picked and, if it has an edge, updated, and a last
// step hands the result over. The request side opens again in the same cycle as the
// response becomes valid. The hand-over waits only while an earlier response is still
// held and not taken; a finished response waits in its own register, so the next request
// is taken while the previous response is still pending. Register writes are always
// accepted and are meant to be made while no request is in flight.
module rc_pwm_receiver_mode_control_core (
   input  logic        clock,
   input  logic        reset,
   rcpwm_req_if.sink   req_chan,
   rcpwm_rsp_if.source rsp_chan,
   rcpwm_csr_if.sink   csr_chan
);
   import rcpwm_pkg::*;

   // configuration registers
   logic [7:0]  scale_ff, scale_in;
   logic [7:0]  qualify_ff, qualify_in;
   logic [15:0] pmin_ff, pmin_in;
   logic [15:0] pshort_ff, pshort_in;
   logic [15:0] plong_ff, plong_in;
   logic [15:0] pmax_ff, pmax_in;
   logic [31:0] ftimeout_ff, ftimeout_in;

   // receiver state
   mode_type    mode_ff, mode_in;
   logic [31:0] rise_ch1_ff, rise_ch1_in;
   logic [31:0] rise_ch2_ff, rise_ch2_in;
   logic [31:0] rise_ch3_ff, rise_ch3_in;
   logic [7:0]  good1_ff, good1_in;
   logic [7:0]  good2_ff, good2_in;
   logic        switch_on_ff, switch_on_in;
   logic        armed_ff, armed_in;

   // sequencer and latched request
   state_type    state_ff, state_in;
   step_type     step_ff, step_in;
   req_kind_type kind_ff, kind_in;
   logic [2:0]   edges_ff, edges_in;
   logic [2:0]   levels_ff, levels_in;
   logic [31:0]  ts_ff, ts_in;
   mode_type     start_ff, start_in;

   // shared divider
   logic [31:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;

   // result accumulators
   servo_type   servo_ff, servo_in;
   logic        d1_ff, d1_in;
   logic        d2_ff, d2_in;
   logic [1:0]  dv_ff, dv_in;
   switch_type  sw_ff, sw_in;
   logic        hb_ff, hb_in;
   note_type    note_ff, note_in;
   logic [15:0] pw1_ff, pw1_in;
   logic [15:0] pw2_ff, pw2_in;
   logic [15:0] pw3_ff, pw3_in;
   logic [2:0]  pv_ff, pv_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  o_mode_ff, o_mode_in;
   logic [1:0]  o_servo_ff, o_servo_in;
   logic        o_d1_ff, o_d1_in;
   logic        o_d2_ff, o_d2_in;
   logic [1:0]  o_dv_ff, o_dv_in;
   logic [1:0]  o_sw_ff, o_sw_in;
   logic        o_hb_ff, o_hb_in;
   logic [1:0]  o_note_ff, o_note_in;
   logic [15:0] o_pw1_ff, o_pw1_in;
   logic [15:0] o_pw2_ff, o_pw2_in;
   logic [15:0] o_pw3_ff, o_pw3_in;
   logic [2:0]  o_pv_ff, o_pv_in;

   // divider datapath: one restoring step
   logic [7:0] divisor;
   logic [8:0] trial;
   logic       trial_ge;
   assign divisor  = (scale_ff == 8'd0) ? 8'd1 : scale_ff;
   assign trial    = {rem_ff, quo_ff[31]};
   assign trial_ge = (trial >= {1'b0, divisor});

   // width compares on the quotient
   logic q_legal, q_short, q_long, q_timeout;
   assign q_legal   = (quo_ff >= {16'd0, pmin_ff}) && (quo_ff <= {16'd0, pmax_ff});
   assign q_short   = (quo_ff <= {16'd0, pshort_ff});
   assign q_long    = (quo_ff >= {16'd0, plong_ff});
   assign q_timeout = (quo_ff >= ftimeout_ff);

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // next state and outputs
   always_comb begin
      logic        has_edge;
      logic        need_div;
      logic [31:0] base;
      logic        reporting;
      step_type    next_step;

      scale_in = scale_ff;   qualify_in = qualify_ff;
      pmin_in = pmin_ff;     pshort_in = pshort_ff;
      plong_in = plong_ff;   pmax_in = pmax_ff;
      ftimeout_in = ftimeout_ff;
      mode_in = mode_ff;
      rise_ch1_in = rise_ch1_ff; rise_ch2_in = rise_ch2_ff; rise_ch3_in = rise_ch3_ff;
      good1_in = good1_ff;   good2_in = good2_ff;
      switch_on_in = switch_on_ff;
      armed_in = armed_ff;
      state_in = state_ff;   step_in = step_ff;
      kind_in = kind_ff;     edges_in = edges_ff;
      levels_in = levels_ff; ts_in = ts_ff;
      start_in = start_ff;
      quo_in = quo_ff;       rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      servo_in = servo_ff;   d1_in = d1_ff;   d2_in = d2_ff;
      dv_in = dv_ff;         sw_in = sw_ff;   hb_in = hb_ff;
      note_in = note_ff;
      pw1_in = pw1_ff;       pw2_in = pw2_ff; pw3_in = pw3_ff;
      pv_in = pv_ff;
      rsp_valid_in = rsp_valid_ff;
      o_mode_in = o_mode_ff;   o_servo_in = o_servo_ff;
      o_d1_in = o_d1_ff;       o_d2_in = o_d2_ff;
      o_dv_in = o_dv_ff;       o_sw_in = o_sw_ff;
      o_hb_in = o_hb_ff;       o_note_in = o_note_ff;
      o_pw1_in = o_pw1_ff;     o_pw2_in = o_pw2_ff;
      o_pw3_in = o_pw3_ff;     o_pv_in = o_pv_ff;
      has_edge = 1'b0;
      need_div = 1'b0;
      base = rise_ch1_ff;
      reporting = (start_ff == MODE_ACTIVE) || (start_ff == MODE_PASS);

      unique case (step_ff)
         STEP_CH2: next_step = STEP_CH1;
         STEP_CH1: next_step = STEP_CH3;
         default:  next_step = STEP_CH3;
      endcase

      // register writes
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SCALE:         scale_in = csr_chan.data[7:0];
            CSR_QUALIFY_COUNT: qualify_in = csr_chan.data[7:0];
            CSR_PULSE_MIN:     pmin_in = csr_chan.data[15:0];
            CSR_PULSE_SHORT:   pshort_in = csr_chan.data[15:0];
            CSR_PULSE_LONG:    plong_in = csr_chan.data[15:0];
            CSR_PULSE_MAX:     pmax_in = csr_chan.data[15:0];
            CSR_FRAME_TIMEOUT: ftimeout_in = csr_chan.data;
            default: ;
         endcase
      end

      // response taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in   = req_kind_type'(req_chan.req_type);
               edges_in  = req_chan.edge_mask;
               levels_in = req_chan.pin_levels;
               ts_in     = req_chan.timestamp;
               start_in  = mode_ff;
               step_in   = STEP_CH2;
               servo_in  = SERVO_NONE;
               d1_in = 1'b0; d2_in = 1'b0; dv_in = 2'd0;
               sw_in = SW_NONE; hb_in = 1'b1; note_in = NOTE_NONE;
               pw1_in = 16'd0; pw2_in = 16'd0; pw3_in = 16'd0; pv_in = 3'd0;
               state_in = ST_PICK;
            end
         end

         // decide whether the current step needs a division
         ST_PICK: begin
            unique case (kind_ff)
               REQ_EDGE: begin
                  unique case (step_ff)
                     STEP_CH2: begin
                        has_edge = edges_ff[1];
                        need_div = !levels_ff[1] || (start_ff == MODE_ACTIVE);
                        base     = levels_ff[1] ? rise_ch1_ff : rise_ch2_ff;
                     end
                     STEP_CH1: begin
                        has_edge = edges_ff[0];
                        need_div = !levels_ff[0];
                        base     = rise_ch1_ff;
                     end
                     default: begin
                        has_edge = edges_ff[2];
                        need_div = !levels_ff[2];
                        base     = rise_ch3_ff;
                     end
                  endcase
               end
               REQ_HEARTBEAT: begin
                  has_edge = 1'b1;
                  need_div = 1'b1;
                  base     = rise_ch2_ff;
               end
               default: begin
                  has_edge = 1'b1;
                  need_div = 1'b0;
               end
            endcase
            if (has_edge) begin
               if (need_div) begin
                  quo_in     = ts_ff - base;
                  rem_in     = 8'd0;
                  div_cnt_in = 5'd0;
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_APPLY;
               end
            end else if (step_ff == STEP_CH3) begin
               state_in = ST_FINISH;
            end else begin
               step_in = next_step;
            end
         end

         // one quotient bit per cycle
         ST_DIV: begin
            rem_in     = trial_ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
            quo_in     = {quo_ff[30:0], trial_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_APPLY;
            end
         end

         // state update for the current step
         ST_APPLY: begin
            unique case (kind_ff)
               REQ_EDGE: begin
                  unique case (step_ff)
                     STEP_CH2: begin
                        if (start_ff == MODE_PASS) begin
                           d2_in = levels_ff[1];
                           dv_in[1] = 1'b1;
                        end
                        if (levels_ff[1]) begin
                           rise_ch2_in = ts_ff;
                           if (start_ff == MODE_ACTIVE && q_timeout) begin
                              mode_in  = MODE_FAILSAFE;
                              servo_in = SERVO_FAILSAFE;
                           end
                        end else begin
                           pw2_in   = sat16(quo_ff);
                           pv_in[1] = 1'b1;
                           if (q_legal) begin
                              if (start_ff == MODE_ACTIVE && (q_short || q_long)) begin
                                 mode_in  = MODE_PASS;
                                 servo_in = SERVO_PASS;
                                 d2_in    = 1'b0;
                                 dv_in[1] = 1'b1;
                              end else if (good2_ff >= qualify_ff) begin
                                 if (start_ff == MODE_NONE) begin
                                    armed_in = 1'b0;
                                    mode_in  = MODE_READY;
                                    note_in  = NOTE_READY;
                                 end
                              end else begin
                                 good2_in = good2_ff + 8'd1;
                              end
                           end else begin
                              good2_in = 8'd0;
                           end
                        end
                     end
                     STEP_CH1: begin
                        if (start_ff == MODE_PASS) begin
                           d1_in = levels_ff[0];
                           dv_in[0] = 1'b1;
                        end
                        if (levels_ff[0]) begin
                           rise_ch1_in = ts_ff;
                        end else begin
                           pw1_in   = sat16(quo_ff);
                           pv_in[0] = 1'b1;
                           if (q_legal) begin
                              if (good1_ff >= qualify_ff) begin
                                 if (start_ff == MODE_READY) begin
                                    mode_in = MODE_ACTIVE;
                                    note_in = NOTE_ACTIVE;
                                 end
                              end else begin
                                 good1_in = good1_ff + 8'd1;
                              end
                           end else begin
                              good1_in = 8'd0;
                           end
                        end
                     end
                     default: begin
                        if (levels_ff[2]) begin
                           rise_ch3_in = ts_ff;
                        end else begin
                           pw3_in   = sat16(quo_ff);
                           pv_in[2] = 1'b1;
                           // hysteresis switch
                           if (q_legal) begin
                              if (q_short) begin
                                 if (switch_on_ff) begin
                                    switch_on_in = 1'b0;
                                    if (reporting) sw_in = SW_OFF;
                                 end
                              end else if (q_long) begin
                                 if (!switch_on_ff) begin
                                    switch_on_in = 1'b1;
                                    if (reporting) sw_in = SW_ON;
                                 end
                              end
                           end
                        end
                     end
                  endcase
               end
               REQ_HEARTBEAT: begin
                  if (q_timeout && mode_ff != MODE_NONE && mode_ff != MODE_FAULT) begin
                     mode_in  = MODE_FAILSAFE;
                     servo_in = SERVO_FAILSAFE;
                     hb_in    = 1'b0;
                  end
               end
               REQ_STARTUP: begin
                  if (armed_ff) begin
                     armed_in = 1'b0;
                     mode_in  = MODE_FAULT;
                     servo_in = SERVO_PASS;
                     note_in  = NOTE_FAULT;
                  end
               end
               default: begin
                  mode_in  = MODE_NONE;
                  servo_in = SERVO_AUTO;
                  armed_in = 1'b1;
               end
            endcase
            if (kind_ff == REQ_EDGE && step_ff != STEP_CH3) begin
               step_in  = next_step;
               state_in = ST_PICK;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // hand the result to the response register
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               o_mode_in  = mode_ff;
               o_servo_in = servo_ff;
               o_d1_in    = d1_ff;
               o_d2_in    = d2_ff;
               o_dv_in    = dv_ff;
               o_sw_in    = sw_ff;
               o_hb_in    = hb_ff;
               o_note_in  = note_ff;
               o_pw1_in   = pw1_ff;
               o_pw2_in   = pw2_ff;
               o_pw3_in   = pw3_ff;
               o_pv_in    = pv_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         qualify_ff   <= QUALIFY_COUNT_RESET;
         pmin_ff      <= PULSE_MIN_RESET;
         pshort_ff    <= PULSE_SHORT_RESET;
         plong_ff     <= PULSE_LONG_RESET;
         pmax_ff      <= PULSE_MAX_RESET;
         ftimeout_ff  <= FRAME_TIMEOUT_RESET;
         mode_ff      <= MODE_NONE;
         rise_ch1_ff  <= 32'd0;
         rise_ch2_ff  <= 32'd0;
         rise_ch3_ff  <= 32'd0;
         good1_ff     <= 8'd0;
         good2_ff     <= 8'd0;
         switch_on_ff <= 1'b0;
         armed_ff     <= 1'b1;
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CH2;
         div_cnt_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         qualify_ff   <= qualify_in;
         pmin_ff      <= pmin_in;
         pshort_ff    <= pshort_in;
         plong_ff     <= plong_in;
         pmax_ff      <= pmax_in;
         ftimeout_ff  <= ftimeout_in;
         mode_ff      <= mode_in;
         rise_ch1_ff  <= rise_ch1_in;
         rise_ch2_ff  <= rise_ch2_in;
         rise_ch3_ff  <= rise_ch3_in;
         good1_ff     <= good1_in;
         good2_ff     <= good2_in;
         switch_on_ff <= switch_on_in;
         armed_ff     <= armed_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      edges_ff  <= edges_in;
      levels_ff <= levels_in;
      ts_ff     <= ts_in;
      start_ff  <= start_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      servo_ff  <= servo_in;
      d1_ff     <= d1_in;
      d2_ff     <= d2_in;
      dv_ff     <= dv_in;
      sw_ff     <= sw_in;
      hb_ff     <= hb_in;
      note_ff   <= note_in;
      pw1_ff    <= pw1_in;
      pw2_ff    <= pw2_in;
      pw3_ff    <= pw3_in;
      pv_ff     <= pv_in;
      o_mode_ff  <= o_mode_in;
      o_servo_ff <= o_servo_in;
      o_d1_ff    <= o_d1_in;
      o_d2_ff    <= o_d2_in;
      o_dv_ff    <= o_dv_in;
      o_sw_ff    <= o_sw_in;
      o_hb_ff    <= o_hb_in;
      o_note_ff  <= o_note_in;
      o_pw1_ff   <= o_pw1_in;
      o_pw2_ff   <= o_pw2_in;
      o_pw3_ff   <= o_pw3_in;
      o_pv_ff    <= o_pv_in;
   end

   // response channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mode         = o_mode_ff;
   assign rsp_chan.servo_cmd    = o_servo_ff;
   assign rsp_chan.ch1_drive    = o_d1_ff;
   assign rsp_chan.ch2_drive    = o_d2_ff;
   assign rsp_chan.drive_valid  = o_dv_ff;
   assign rsp_chan.switch_event = o_sw_ff;
   assign rsp_chan.heartbeat_ok = o_hb_ff;
   assign rsp_chan.notify       = o_note_ff;
   assign rsp_chan.ch1_pulse    = o_pw1_ff;
   assign rsp_chan.ch2_pulse    = o_pw2_ff;
   assign rsp_chan.ch3_pulse    = o_pw3_ff;
   assign rsp_chan.pulse_valid  = o_pv_ff;

   // busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while an item was in flight");

   // divider runs all its steps
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff != DIV_LAST) |=> (state_ff == ST_DIV))
      else $error("divider left before its last step");

   // startup timeout is armed only in mode none
   a_armed_none: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (mode_ff == MODE_NONE))
      else $error("startup timeout armed outside mode none");

   // a finished result waits while the response register is full
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_chan.valid && !rsp_chan.ready) |=>
      (state_ff == ST_FINISH))
      else $error("result overwrote a pending response");

endmodule
